// ===== design/pwlt_pkg.sv =====
// Shared types and constants for the pulse-width line transmitter.
// Holds operation codes, register indexes, register reset values and field widths.
// No dependencies.
`default_nettype none

package pwlt_pkg;

   // Operation carried with each input item
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_START = 2'd2
   } op_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_SYNC_LOW  = 3'd0,
      REG_SYNC_HIGH = 3'd1,
      REG_ONE_LOW   = 3'd2,
      REG_ONE_HIGH  = 3'd3,
      REG_ZERO_LOW  = 3'd4,
      REG_ZERO_HIGH = 3'd5,
      REG_STOP_LOW  = 3'd6
   } reg_index_type;

   localparam int unsigned TICKS_W  = 16;
   localparam int unsigned SLOT_W   = 4;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LENGTH_W = 5;
   localparam int unsigned INDEX_W  = 3;

   typedef logic [TICKS_W-1:0] ticks_type;

   // Register values after reset
   localparam ticks_type SYNC_LOW_RESET  = 16'd40000;
   localparam ticks_type SYNC_HIGH_RESET = 16'd2000;
   localparam ticks_type ONE_LOW_RESET   = 16'd2000;
   localparam ticks_type ONE_HIGH_RESET  = 16'd4000;
   localparam ticks_type ZERO_LOW_RESET  = 16'd4000;
   localparam ticks_type ZERO_HIGH_RESET = 16'd2000;
   localparam ticks_type STOP_LOW_RESET  = 16'd10000;

   // Result fields of one item
   typedef struct packed {
      logic frame_done;
      logic busy_res;
      logic line_level;
   } result_type;

   // A programmed length of zero counts as one tick
   function automatic ticks_type span_len(input ticks_type value);
      span_len = (value == '0) ? ticks_type'(1) : value;
   endfunction

endpackage

`default_nettype wire

// ===== design/pulse_width_line_transmitter_top.sv =====
// Top level of the pulse-width line transmitter: frame buffer, symbol sequencer,
// configuration registers and result register with skid stage.
// Depends on pwlt_pkg.
`default_nettype none

// The block takes one item per clock while req_tready is high: a tick, a frame byte
// write or a frame start (req_tuser). Each accepted item yields exactly one result
// item, the line level and busy flag after that step, with rsp_tlast high on the
// tick that ends the stop span and releases the line. Every item passes through one
// combinational step between the state registers and the result register, so items
// may arrive back to back; a skid register behind the result register keeps
// req_tready high while one result waits on rsp_tready. The frame buffer is a small
// memory with a registered read port that fetches the byte of the next bit ahead of
// use, so byte writes and starts are only honored while idle. Span lengths are
// sampled from the csr registers when a span begins; write them only while idle.
module pulse_width_line_transmitter_top #(
   parameter int unsigned FRAME_BYTES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input item channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [3:0] byte_slot, [11:4] byte_value,
                                         // [16:12] frame_length, [23:17] zero
   input  wire logic [1:0]  req_tuser,   // [1:0] operation
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [0] line_level, [1] busy_res, [7:2] zero
   output logic             rsp_tlast,   // frame_done
   // configuration write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int unsigned AW        = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   localparam int unsigned MEM_DEPTH = 1 << AW;
   localparam int unsigned POS_W     = $clog2(8 * FRAME_BYTES + 1);
   localparam logic [8:0]  FrameBytesW = 9'(FRAME_BYTES);

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_SYNC_LOW  = 3'd1,
      PH_SYNC_HIGH = 3'd2,
      PH_BIT_LOW   = 3'd3,
      PH_BIT_HIGH  = 3'd4,
      PH_STOP_LOW  = 3'd5
   } phase_type;

   // configuration registers
   pwlt_pkg::ticks_type sync_low_ff, sync_high_ff, one_low_ff, one_high_ff;
   pwlt_pkg::ticks_type zero_low_ff, zero_high_ff, stop_low_ff;

   // sequencer state
   phase_type           phase_ff, phase_in;
   pwlt_pkg::ticks_type ticks_ff, ticks_in;
   logic [POS_W-1:0]    next_pos_ff, next_pos_in;
   logic [POS_W-1:0]    total_ff, total_in;
   logic                bit_ff, bit_in;
   logic                line_ff, line_in;
   logic                done;

   // frame buffer
   logic [7:0]          mem [MEM_DEPTH];
   logic [7:0]          rd_data_ff;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;

   // result register and skid stage
   logic                out_valid_ff, out_valid_in;
   pwlt_pkg::result_type out_ff, out_in;
   logic                skid_valid_ff, skid_valid_in;
   pwlt_pkg::result_type skid_ff, skid_in;

   logic                req_accept;
   logic                rsp_accept;
   pwlt_pkg::op_type    op;
   logic [3:0]          slot;
   logic [7:0]          byte_value;
   logic [4:0]          frame_length;
   logic [8:0]          eff_len;
   pwlt_pkg::ticks_type ticks_dec;
   pwlt_pkg::result_type result;

   assign req_tready   = !skid_valid_ff;
   assign req_accept   = req_tvalid && req_tready;
   assign rsp_accept   = out_valid_ff && rsp_tready;
   assign csr_ready    = 1'b1;

   assign op           = pwlt_pkg::op_type'(req_tuser);
   assign slot         = req_tdata[3:0];
   assign byte_value   = req_tdata[11:4];
   assign frame_length = req_tdata[16:12];

   // clamp the frame length to the buffer size
   assign eff_len   = (9'(frame_length) > FrameBytesW) ? FrameBytesW : 9'(frame_length);
   assign ticks_dec = (ticks_ff != '0) ? ticks_ff - 1'b1 : ticks_ff;
   assign mem_waddr = AW'(slot);

   // advance the sequencer for one accepted item
   always_comb begin
      phase_in    = phase_ff;
      ticks_in    = ticks_ff;
      next_pos_in = next_pos_ff;
      total_in    = total_ff;
      bit_in      = bit_ff;
      line_in     = line_ff;
      done        = 1'b0;
      mem_we      = 1'b0;
      if (req_accept) begin
         unique case (op)
            pwlt_pkg::OP_WRITE: begin
               mem_we = (phase_ff == PH_IDLE) && (9'(slot) < FrameBytesW);
            end
            pwlt_pkg::OP_START: begin
               if (phase_ff == PH_IDLE) begin
                  total_in    = POS_W'({eff_len, 3'b000});
                  next_pos_in = '0;
                  bit_in      = 1'b0;
                  line_in     = 1'b0;
                  ticks_in    = pwlt_pkg::span_len(sync_low_ff);
                  phase_in    = PH_SYNC_LOW;
               end
            end
            pwlt_pkg::OP_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  ticks_in = ticks_dec;
                  if (ticks_dec == '0) begin
                     unique case (phase_ff)
                        PH_SYNC_LOW: begin
                           line_in  = 1'b1;
                           ticks_in = pwlt_pkg::span_len(sync_high_ff);
                           phase_in = PH_SYNC_HIGH;
                        end
                        PH_BIT_LOW: begin
                           line_in  = 1'b1;
                           ticks_in = pwlt_pkg::span_len(bit_ff ? one_high_ff : zero_high_ff);
                           phase_in = PH_BIT_HIGH;
                        end
                        PH_SYNC_HIGH, PH_BIT_HIGH: begin
                           line_in = 1'b0;
                           if (next_pos_ff >= total_ff) begin
                              ticks_in = pwlt_pkg::span_len(stop_low_ff);
                              phase_in = PH_STOP_LOW;
                           end else begin
                              bit_in      = rd_data_ff[~next_pos_ff[2:0]];
                              ticks_in    = pwlt_pkg::span_len(
                                               bit_in ? one_low_ff : zero_low_ff);
                              next_pos_in = next_pos_ff + 1'b1;
                              phase_in    = PH_BIT_LOW;
                           end
                        end
                        PH_STOP_LOW: begin
                           line_in  = 1'b1;
                           phase_in = PH_IDLE;
                           done     = 1'b1;
                        end
                        default: begin
                           line_in  = 1'b1;
                           phase_in = PH_IDLE;
                        end
                     endcase
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign result = '{frame_done: done,
                     busy_res:   (phase_in != PH_IDLE),
                     line_level: line_in};

   // route results through the output register and skid stage
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (rsp_accept) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (req_accept) begin
            out_in = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (req_accept) begin
         if (out_valid_ff) begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = result;
            out_valid_in = 1'b1;
         end
      end
   end

   // hold sequencer, configuration and handshake state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         ticks_ff      <= '0;
         next_pos_ff   <= '0;
         total_ff      <= '0;
         bit_ff        <= 1'b0;
         line_ff       <= 1'b1;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         sync_low_ff   <= pwlt_pkg::SYNC_LOW_RESET;
         sync_high_ff  <= pwlt_pkg::SYNC_HIGH_RESET;
         one_low_ff    <= pwlt_pkg::ONE_LOW_RESET;
         one_high_ff   <= pwlt_pkg::ONE_HIGH_RESET;
         zero_low_ff   <= pwlt_pkg::ZERO_LOW_RESET;
         zero_high_ff  <= pwlt_pkg::ZERO_HIGH_RESET;
         stop_low_ff   <= pwlt_pkg::STOP_LOW_RESET;
      end else begin
         phase_ff      <= phase_in;
         ticks_ff      <= ticks_in;
         next_pos_ff   <= next_pos_in;
         total_ff      <= total_in;
         bit_ff        <= bit_in;
         line_ff       <= line_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (pwlt_pkg::reg_index_type'(csr_index))
               pwlt_pkg::REG_SYNC_LOW:  sync_low_ff  <= csr_data;
               pwlt_pkg::REG_SYNC_HIGH: sync_high_ff <= csr_data;
               pwlt_pkg::REG_ONE_LOW:   one_low_ff   <= csr_data;
               pwlt_pkg::REG_ONE_HIGH:  one_high_ff  <= csr_data;
               pwlt_pkg::REG_ZERO_LOW:  zero_low_ff  <= csr_data;
               pwlt_pkg::REG_ZERO_HIGH: zero_high_ff <= csr_data;
               pwlt_pkg::REG_STOP_LOW:  stop_low_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // hold result payloads
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // write the frame buffer and fetch the byte of the next bit ahead of use
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= byte_value;
      end
      rd_data_ff <= mem[next_pos_ff[AW+2:3]];
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b000000, out_ff.busy_res, out_ff.line_level};
   assign rsp_tlast  = out_ff.frame_done;

`ifndef SYNTHESIS
   // line is only driven low while a frame is in progress
   a_low_only_busy: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> line_ff)
      else $error("line low while idle");

   // an active span always has ticks left to count
   a_ticks_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (ticks_ff != '0))
      else $error("active span with zero ticks");

   // a held result must stand behind a valid output register
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result without output register");

   // a start taken while idle opens the sync low span
   a_start_sync: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (op == pwlt_pkg::OP_START) && (phase_ff == PH_IDLE))
      |=> ((phase_ff == PH_SYNC_LOW) && !line_ff))
      else $error("start did not open sync low");

   // a frame end result reports the released line and idle state
   a_done_released: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.frame_done) |-> (out_ff.line_level && !out_ff.busy_res))
      else $error("frame end with line not released");
`endif

endmodule

`default_nettype wire

// ===== sim/pulse_width_line_transmitter_top_test.sv =====
// Self-checking bench for the pulse-width line transmitter: drives tick, byte write
// and start items under random gaps and stalls, predicts line level, busy and frame end.
// Depends on pwlt_pkg and pulse_width_line_transmitter_top.
`default_nettype none

module pulse_width_line_transmitter_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FRAME_BYTES   = 16;
   localparam int unsigned NUM_REGS      = 7;
   localparam logic [1:0]  OP_UNUSED     = 2'd3;
   localparam longint unsigned CYCLE_LIMIT = 200_000;
   localparam int unsigned SETTLE_CYCLES = 20;
   localparam int unsigned ITEMS_PER_PHASE = 100;
   localparam int unsigned REPORT_LIMIT  = 10;

   typedef enum logic [2:0] {
      LINE_IDLE,
      SYNC_LOW_SPAN,
      SYNC_HIGH_SPAN,
      BIT_LOW_SPAN,
      BIT_HIGH_SPAN,
      STOP_SPAN
   } line_phase_type;

   typedef struct packed {
      logic [1:0]                    op;
      logic [pwlt_pkg::SLOT_W-1:0]   slot;
      logic [pwlt_pkg::BYTE_W-1:0]   value;
      logic [pwlt_pkg::LENGTH_W-1:0] length;
   } line_item_type;

   // DUT ports
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = pwlt_pkg::OP_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index  = '0;
   logic [15:0] csr_data   = '0;

   // Line model state
   pwlt_pkg::ticks_type span_cfg [NUM_REGS];
   logic [7:0]     byte_store [FRAME_BYTES];
   line_phase_type line_phase;
   int unsigned    ticks_left;
   int unsigned    bit_index;
   int unsigned    bit_count;
   logic           cur_bit;
   logic           line_high;

   line_item_type          pending_items [$];
   pwlt_pkg::result_type   expected_results [$];
   line_item_type   driven_item;
   int unsigned     sender_idle_pct = 0;
   int unsigned     rsp_stall_pct   = 0;
   int unsigned     mismatches      = 0;
   int unsigned     results_seen    = 0;
   int unsigned     stim_effective  = 0;
   longint unsigned cycle_count     = 0;

   pulse_width_line_transmitter_top #(
      .FRAME_BYTES(FRAME_BYTES)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Programmed length, with zero counted as one tick
   function automatic int unsigned span_ticks(input pwlt_pkg::reg_index_type r);
      return (span_cfg[r] == '0) ? 1 : span_cfg[r];
   endfunction

   // Start the next data bit, or the stop span once all bits are out
   function automatic void open_bit_or_stop();
      if (bit_index >= bit_count) begin
         line_high  = 1'b0;
         ticks_left = span_ticks(pwlt_pkg::REG_STOP_LOW);
         line_phase = STOP_SPAN;
      end else begin
         cur_bit    = byte_store[bit_index / 8][7 - (bit_index % 8)];
         line_high  = 1'b0;
         ticks_left = span_ticks(cur_bit ? pwlt_pkg::REG_ONE_LOW : pwlt_pkg::REG_ZERO_LOW);
         line_phase = BIT_LOW_SPAN;
      end
   endfunction

   // Advance the line model by one item and return the expected result
   function automatic pwlt_pkg::result_type step_line(input line_item_type it);
      logic                 done;
      int unsigned          len;
      pwlt_pkg::result_type r;
      done = 1'b0;
      case (it.op)
         pwlt_pkg::OP_WRITE: begin
            if (line_phase == LINE_IDLE)
               byte_store[it.slot] = it.value;
         end
         pwlt_pkg::OP_START: begin
            if (line_phase == LINE_IDLE) begin
               len        = (it.length > FRAME_BYTES) ? FRAME_BYTES : it.length;
               bit_count  = len * 8;
               bit_index  = 0;
               cur_bit    = 1'b0;
               line_high  = 1'b0;
               ticks_left = span_ticks(pwlt_pkg::REG_SYNC_LOW);
               line_phase = SYNC_LOW_SPAN;
            end
         end
         pwlt_pkg::OP_TICK: begin
            if (line_phase != LINE_IDLE) begin
               if (ticks_left > 0)
                  ticks_left--;
               if (ticks_left == 0) begin
                  case (line_phase)
                     SYNC_LOW_SPAN: begin
                        line_high  = 1'b1;
                        ticks_left = span_ticks(pwlt_pkg::REG_SYNC_HIGH);
                        line_phase = SYNC_HIGH_SPAN;
                     end
                     SYNC_HIGH_SPAN: open_bit_or_stop();
                     BIT_LOW_SPAN: begin
                        line_high  = 1'b1;
                        ticks_left = span_ticks(cur_bit ? pwlt_pkg::REG_ONE_HIGH
                                                        : pwlt_pkg::REG_ZERO_HIGH);
                        line_phase = BIT_HIGH_SPAN;
                     end
                     BIT_HIGH_SPAN: begin
                        bit_index++;
                        open_bit_or_stop();
                     end
                     STOP_SPAN: begin
                        line_high  = 1'b1;
                        line_phase = LINE_IDLE;
                        done       = 1'b1;
                     end
                     default: begin
                        line_high  = 1'b1;
                        line_phase = LINE_IDLE;
                     end
                  endcase
               end
            end
         end
         default: ;
      endcase
      r.line_level = line_high;
      r.busy_res   = (line_phase != LINE_IDLE);
      r.frame_done = done;
      return r;
   endfunction

   // Ticks from a start of the given length until the line is released
   function automatic int unsigned frame_span_total(input int unsigned len);
      int unsigned total;
      int unsigned nbits;
      logic        b;
      nbits = ((len > FRAME_BYTES) ? FRAME_BYTES : len) * 8;
      total = span_ticks(pwlt_pkg::REG_SYNC_LOW) + span_ticks(pwlt_pkg::REG_SYNC_HIGH)
            + span_ticks(pwlt_pkg::REG_STOP_LOW);
      for (int unsigned i = 0; i < nbits; i++) begin
         b = byte_store[i / 8][7 - (i % 8)];
         total += b ? span_ticks(pwlt_pkg::REG_ONE_LOW) + span_ticks(pwlt_pkg::REG_ONE_HIGH)
                    : span_ticks(pwlt_pkg::REG_ZERO_LOW) + span_ticks(pwlt_pkg::REG_ZERO_HIGH);
      end
      return total;
   endfunction

   // Input item of the given operation with random content in every field
   function automatic line_item_type random_item(input logic [1:0] op);
      line_item_type it;
      it.op     = op;
      it.slot   = 4'($urandom_range(15));
      it.value  = 8'($urandom_range(255));
      it.length = 5'($urandom_range(31));
      return it;
   endfunction

   // Compare one result item with the oldest expectation
   task automatic check_result(input pwlt_pkg::result_type got);
      pwlt_pkg::result_type want;
      results_seen++;
      if (expected_results.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("result %0d: none expected, got line %0b busy %0b done %0b",
                     results_seen, got.line_level, got.busy_res, got.frame_done);
      end else begin
         want = expected_results.pop_front();
         if (got.line_level !== want.line_level || got.busy_res !== want.busy_res ||
             got.frame_done !== want.frame_done) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("result %0d: expected line %0b busy %0b done %0b, got %0b %0b %0b",
                        results_seen, want.line_level, want.busy_res, want.frame_done,
                        got.line_level, got.busy_res, got.frame_done);
         end
      end
   endtask

   // Driver: predict on acceptance, then present the next queued item or idle
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_results.push_back(step_line(driven_item));
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               driven_item = pending_items.pop_front();
               req_tdata  <= {7'd0, driven_item.length, driven_item.value, driven_item.slot};
               req_tuser  <= driven_item.op;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check accepted results, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_result(pwlt_pkg::result_type'({rsp_tlast, rsp_tdata[1:0]}));
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("pulse_width_line_transmitter_top: mismatch");
         $finish;
      end
   end

   // Hold until every queued item is sent and every result has come back
   task automatic wait_drained();
      while (pending_items.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   // Write one span register; only called while the line is idle and drained
   task automatic write_reg(input pwlt_pkg::reg_index_type idx,
                            input pwlt_pkg::ticks_type value);
      @(posedge clock);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      span_cfg[idx] = value;
      csr_valid <= 1'b0;
   endtask

   // Feed ticks span by span until the model is back to idle
   task automatic finish_frame();
      while (line_phase != LINE_IDLE) begin
         repeat ((ticks_left == 0) ? 1 : ticks_left)
            pending_items.push_back(random_item(pwlt_pkg::OP_TICK));
         wait_drained();
      end
   endtask

   // Start a frame and stream its ticks, sprinkled with items the busy block drops
   task automatic send_frame(input int unsigned len, input int unsigned noise_pct,
                             input bit cut_short);
      int unsigned   span_total;
      int unsigned   tick_goal;
      int unsigned   sent;
      line_item_type it;
      wait_drained();
      span_total = frame_span_total(len);
      tick_goal  = cut_short ? $urandom_range(span_total - 1) : span_total;
      it = random_item(pwlt_pkg::OP_START);
      it.length = 5'(len);
      pending_items.push_back(it);
      sent = 0;
      while (sent < tick_goal) begin
         if ($urandom_range(99) < noise_pct) begin
            case ($urandom_range(2))
               0:       pending_items.push_back(random_item(pwlt_pkg::OP_WRITE));
               1:       pending_items.push_back(random_item(pwlt_pkg::OP_START));
               default: pending_items.push_back(random_item(OP_UNUSED));
            endcase
         end else begin
            pending_items.push_back(random_item(pwlt_pkg::OP_TICK));
            sent++;
         end
      end
      wait_drained();
      finish_frame();
      stim_effective += 1 + span_total;
   endtask

   function automatic pwlt_pkg::ticks_type random_span();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 50)
         return 16'($urandom_range(2));
      else if (r < 90)
         return 16'($urandom_range(8, 3));
      return 16'($urandom_range(40, 9));
   endfunction

   function automatic int unsigned random_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 75)
         return $urandom_range(2, 1);
      else if (r < 90)
         return $urandom_range(6, 3);
      else if (r < 96)
         return 0;
      return $urandom_range(31, 17);
   endfunction

   // One random frame: maybe retune spans, write some bytes, send
   task automatic random_round();
      wait_drained();
      if ($urandom_range(3) == 0) begin
         for (int r = 0; r < NUM_REGS; r++)
            if ($urandom_range(1) == 1)
               write_reg(pwlt_pkg::reg_index_type'(r), random_span());
      end
      repeat ($urandom_range(5)) begin
         pending_items.push_back(random_item(pwlt_pkg::OP_WRITE));
         stim_effective++;
      end
      repeat ($urandom_range(2))
         pending_items.push_back(random_item($urandom_range(1) ? OP_UNUSED
                                                               : pwlt_pkg::OP_TICK));
      send_frame(random_length(), 10, $urandom_range(9) == 0);
   endtask

   initial begin
      span_cfg[pwlt_pkg::REG_SYNC_LOW]  = pwlt_pkg::SYNC_LOW_RESET;
      span_cfg[pwlt_pkg::REG_SYNC_HIGH] = pwlt_pkg::SYNC_HIGH_RESET;
      span_cfg[pwlt_pkg::REG_ONE_LOW]   = pwlt_pkg::ONE_LOW_RESET;
      span_cfg[pwlt_pkg::REG_ONE_HIGH]  = pwlt_pkg::ONE_HIGH_RESET;
      span_cfg[pwlt_pkg::REG_ZERO_LOW]  = pwlt_pkg::ZERO_LOW_RESET;
      span_cfg[pwlt_pkg::REG_ZERO_HIGH] = pwlt_pkg::ZERO_HIGH_RESET;
      span_cfg[pwlt_pkg::REG_STOP_LOW]  = pwlt_pkg::STOP_LOW_RESET;
      foreach (byte_store[i])
         byte_store[i] = '0;
      line_phase = LINE_IDLE;
      ticks_left = 0;
      bit_index  = 0;
      bit_count  = 0;
      cur_bit    = 1'b0;
      line_high  = 1'b1;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Idle tick and unused operation, then fill every slot
      pending_items.push_back(random_item(pwlt_pkg::OP_TICK));
      pending_items.push_back(random_item(OP_UNUSED));
      for (int i = 0; i < FRAME_BYTES; i++) begin
         line_item_type it;
         it = random_item(pwlt_pkg::OP_WRITE);
         it.slot  = 4'(i);
         it.value = (i == 0) ? 8'hA5 : (i == 1) ? 8'h00 : (i == 2) ? 8'hFF
                                     : 8'($urandom_range(255));
         pending_items.push_back(it);
      end
      wait_drained();

      // All spans zero: each acts as one tick; oversized length saturates
      for (int r = 0; r < NUM_REGS; r++)
         write_reg(pwlt_pkg::reg_index_type'(r), '0);
      send_frame(31, 20, 1'b0);
      send_frame(0, 0, 1'b0);

      // Sync span past eight counter bits, shortest bit spans
      for (int r = 0; r < NUM_REGS; r++)
         write_reg(pwlt_pkg::reg_index_type'(r), 16'd1);
      write_reg(pwlt_pkg::REG_SYNC_LOW, 16'd257);
      write_reg(pwlt_pkg::REG_STOP_LOW, 16'd20);
      send_frame(2, 0, 1'b0);
      write_reg(pwlt_pkg::REG_SYNC_LOW, 16'd1);
      write_reg(pwlt_pkg::REG_STOP_LOW, 16'd1);

      // Random frames under each idling mix
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 48; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 48; end
            default: begin sender_idle_pct = 30; rsp_stall_pct = 30; end
         endcase
         stim_effective = 0;
         while (stim_effective < ITEMS_PER_PHASE)
            random_round();
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("pulse_width_line_transmitter_top: match");
      else
         $display("pulse_width_line_transmitter_top: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
